[src/triangle_tangent_from_texcoords_unit_defines.svh]
// assertion macros for the tangent unit
`ifndef TRIANGLE_TANGENT_FROM_TEXCOORDS_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_FROM_TEXCOORDS_UNIT_DEFINES_SVH
// property that must hold whenever out of reset
`define TTU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define TTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/ttu_pkg.sv]
// shared types and constants for the tangent unit
package ttu_pkg;
    localparam int unsigned CoordWidth  = 32;
    localparam int unsigned OutWidth    = 16;
    localparam int unsigned DeltaWidth  = 33;
    localparam int unsigned ProdWidth   = 67;
    localparam int unsigned MagWidth    = 30;
    localparam int unsigned SumWidth    = 62;
    localparam int unsigned RootWidth   = 31;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET,
        ST_TAN,
        ST_NORM,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctrl;

    // one vertex transfer
    typedef struct packed {
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] pos_z;
        logic signed [CoordWidth-1:0] tex_u;
        logic signed [CoordWidth-1:0] tex_v;
    } t_vertex;

    // one tangent transfer
    typedef struct packed {
        logic signed [OutWidth-1:0] tangent_x;
        logic signed [OutWidth-1:0] tangent_y;
        logic signed [OutWidth-1:0] tangent_z;
        logic                       degenerate;
    } t_tangent;
endpackage

[src/ttu_if.sv]
// valid/ready channel carrying a payload
interface ttu_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ttu_div.sv]
// restoring divider, one quotient bit a cycle
module ttu_div #(
    parameter int unsigned NUM_W = 60,
    parameter int unsigned DEN_W = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);
    import ttu_pkg::*;

    localparam int unsigned CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    t_div_ctrl        r_ctl, n_ctl;
    logic [DEN_W:0]   w_try;

    // shift in one numerator bit and trial subtract
    always_comb begin
        w_try = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        n_num = r_num;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_ctl = r_ctl;
        n_ctl.start = 1'b0;
        if (i_start) begin
            n_num = i_num;
            n_rem = '0;
            n_cnt = CntW'(NUM_W);
            n_ctl.busy = 1'b1;
        end else if (r_ctl.busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_ctl.busy  = 1'b0;
                n_ctl.start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_cnt <= '0;
        end else begin
            r_ctl <= n_ctl;
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_ctl.start;
    assign o_quot = r_num;
endmodule

[src/triangle_tangent_from_texcoords_unit.sv]
// per-triangle unit tangent from texture-coordinate deltas
// vertices one and two: stored, no result
// third vertex: result valid after the sequence below, with 14 fraction bits
// (determinant, tangent, scale, shift and square on a shared 34x34 multiplier,
// square root, three divides, output); a zero det or zero tangent skips to output
// input not ready while a triangle is in flight; sync active-low reset clears phase, sequencer and output valid
module triangle_tangent_from_texcoords_unit #(
    parameter int unsigned TANGENT_FRACTION_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ttu_if.sink  i_vtx,
    ttu_if.source o_tan
);
    import ttu_pkg::*;
    `include "triangle_tangent_from_texcoords_unit_defines.svh"

    localparam int unsigned F    = TANGENT_FRACTION_BITS;
    localparam int unsigned NumW = MagWidth + F + 1;

    // held vertices
    logic signed [CoordWidth-1:0] r_p0 [3];
    logic signed [CoordWidth-1:0] r_p1 [3];
    logic signed [CoordWidth-1:0] r_p2 [3];
    logic signed [CoordWidth-1:0] r_uv0 [2];
    logic signed [CoordWidth-1:0] r_uv1 [2];
    logic signed [CoordWidth-1:0] r_uv2 [2];
    t_phase r_phase;
    t_state r_state, n_state;
    logic [2:0] r_step, n_step;

    logic signed [ProdWidth-1:0] r_acc;
    logic signed [ProdWidth-1:0] r_det;
    logic signed [ProdWidth-1:0] r_t [3];
    logic [MagWidth-1:0]         r_m [3];
    logic [2:0]                  r_neg;
    logic [6:0]                  r_len;
    logic [SumWidth-1:0]         r_s;
    logic [63:0]                 r_rem, r_res, r_bit;
    logic signed [OutWidth-1:0]  r_out [3];
    logic                        r_deg;
    logic signed [OutWidth-1:0]  r_oval [3];
    logic                        r_odeg;
    logic                        r_ovalid;

    wire w_in_xfer  = i_vtx.valid && i_vtx.ready;
    wire w_out_xfer = o_tan.valid && o_tan.ready;
    // result moves to the output register once that register is free
    wire w_load_out = (r_state == ST_OUT) && (!r_ovalid || w_out_xfer);

    // shared multiplier operands
    logic signed [DeltaWidth:0]   w_ma, w_mb;
    logic signed [ProdWidth:0]    w_prod;
    logic signed [DeltaWidth-1:0] w_d1u, w_d1v, w_d2u, w_d2v;
    logic signed [DeltaWidth-1:0] w_e1 [3];
    logic signed [DeltaWidth-1:0] w_e2 [3];
    logic [1:0]                   w_k, w_div_k;
    logic [RootWidth-1:0]         w_root;

    always_comb begin
        w_d1u = DeltaWidth'(r_uv1[0]) - DeltaWidth'(r_uv0[0]);
        w_d1v = DeltaWidth'(r_uv1[1]) - DeltaWidth'(r_uv0[1]);
        w_d2u = DeltaWidth'(r_uv2[0]) - DeltaWidth'(r_uv0[0]);
        w_d2v = DeltaWidth'(r_uv2[1]) - DeltaWidth'(r_uv0[1]);
        for (int k = 0; k < 3; k++) begin
            w_e1[k] = DeltaWidth'(r_p1[k]) - DeltaWidth'(r_p0[k]);
            w_e2[k] = DeltaWidth'(r_p2[k]) - DeltaWidth'(r_p0[k]);
        end
    end

    // component index for the shift/square steps and the next division
    always_comb begin
        w_k     = (r_step >= 3'd3) ? 2'(r_step - 3'd3) : r_step[1:0];
        w_div_k = (r_state == ST_DIV && r_step[1:0] != 2'd2) ? r_step[1:0] + 2'd1 : 2'd0;
        w_root  = RootWidth'(r_res);
    end

    // operand selection per sequencer step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_DET) begin
            w_ma = (r_step[0]) ? (DeltaWidth+1)'(w_d2u) : (DeltaWidth+1)'(w_d1u);
            w_mb = (r_step[0]) ? (DeltaWidth+1)'(w_d1v) : (DeltaWidth+1)'(w_d2v);
        end else if (r_state == ST_TAN) begin
            w_ma = (r_step[0]) ? (DeltaWidth+1)'(w_d1v) : (DeltaWidth+1)'(w_d2v);
            w_mb = (r_step[0]) ? (DeltaWidth+1)'(w_e2[r_step[2:1]])
                               : (DeltaWidth+1)'(w_e1[r_step[2:1]]);
        end else if (r_state == ST_SQR) begin
            w_ma = (DeltaWidth+1)'({1'b0, r_m[w_k]});
            w_mb = w_ma;
        end
        w_prod = w_ma * w_mb;
    end

    // magnitudes and bit length of their or
    logic [ProdWidth-1:0] w_mag [3];
    logic [ProdWidth-1:0] w_or;
    logic [6:0]           w_blen;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_t[k][ProdWidth-1] ? ProdWidth'(-r_t[k]) : ProdWidth'(r_t[k]);
        end
        w_or = w_mag[0] | w_mag[1] | w_mag[2];
        w_blen = '0;
        for (int k = 0; k < ProdWidth; k++) begin
            if (w_or[k]) w_blen = 7'(k + 1);
        end
    end

    // divider
    logic            w_div_start, w_div_done;
    logic [NumW-1:0] w_div_num, w_div_q;
    assign w_div_num = NumW'({r_m[w_div_k], F'(0)}) + NumW'(w_root >> 1);

    ttu_div #(.NUM_W(NumW), .DEN_W(RootWidth)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_root),
        .o_done (w_div_done),
        .o_quot (w_div_q)
    );

    assign i_vtx.ready = (r_state == ST_IDLE);
    assign o_tan.valid = r_ovalid;
    assign o_tan.data  = {r_oval[0], r_oval[1], r_oval[2], r_odeg};

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && r_phase == PH_THIRD) begin
                    n_state = ST_DET;
                    n_step  = '0;
                end
            end
            ST_DET: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd1) begin
                    n_state = ST_TAN;
                    n_step  = '0;
                end
            end
            ST_TAN: begin
                if (r_det == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                    if (r_step == 3'd5) begin
                        n_state = ST_NORM;
                        n_step  = '0;
                    end
                end
            end
            ST_NORM: begin
                n_state = (w_or == '0) ? ST_OUT : ST_SQR;
                n_step  = '0;
            end
            ST_SQR: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd5) begin
                    n_state = ST_ROOT;
                    n_step  = '0;
                end
            end
            ST_ROOT: begin
                if (r_bit == '0) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                    w_div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_step = r_step + 1'b1;
                    if (r_step == 3'd2) n_state = ST_OUT;
                    else w_div_start = 1'b1;
                end
            end
            ST_OUT: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    logic [NumW-1:0]  w_q;
    logic [ProdWidth-1:0] w_tm;
    logic [63:0] w_rb;
    always_comb begin
        w_q  = (w_div_q > NumW'(1 << F)) ? NumW'(1 << F) : w_div_q;
        w_tm = r_t[w_k];
        w_rb = r_res + r_bit;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_phase  <= PH_FIRST;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_in_xfer) begin
                unique case (r_phase)
                    PH_FIRST:  r_phase <= PH_SECOND;
                    PH_SECOND: r_phase <= PH_THIRD;
                    PH_THIRD:  r_phase <= PH_FIRST;
                    default:   r_phase <= PH_SECOND;
                endcase
            end
            if (w_load_out)      r_ovalid <= 1'b1;
            else if (w_out_xfer) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            if (r_phase == PH_SECOND) begin
                r_p1  <= '{i_vtx.data.pos_x, i_vtx.data.pos_y, i_vtx.data.pos_z};
                r_uv1 <= '{i_vtx.data.tex_u, i_vtx.data.tex_v};
            end else if (r_phase == PH_THIRD) begin
                r_p2  <= '{i_vtx.data.pos_x, i_vtx.data.pos_y, i_vtx.data.pos_z};
                r_uv2 <= '{i_vtx.data.tex_u, i_vtx.data.tex_v};
            end else begin
                r_p0  <= '{i_vtx.data.pos_x, i_vtx.data.pos_y, i_vtx.data.pos_z};
                r_uv0 <= '{i_vtx.data.tex_u, i_vtx.data.tex_v};
            end
            r_deg <= 1'b1;
            r_out <= '{default: '0};
        end
        unique case (r_state)
            ST_DET: begin
                if (r_step == 3'd0) r_acc <= ProdWidth'(w_prod);
                else r_det <= r_acc - ProdWidth'(w_prod);
            end
            ST_TAN: begin
                if (!r_step[0]) begin
                    r_acc <= ProdWidth'(w_prod);
                end else begin
                    r_t[r_step[2:1]] <= r_det[ProdWidth-1]
                        ? ProdWidth'(w_prod) - r_acc : r_acc - ProdWidth'(w_prod);
                end
            end
            ST_NORM: begin
                r_len <= w_blen;
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= r_t[k][ProdWidth-1];
                    r_t[k] <= w_mag[k];
                end
                r_s <= '0;
            end
            ST_SQR: begin
                if (r_step < 3'd3) begin
                    // shift to the common scale
                    if (r_len > 7'(MagWidth)) begin
                        r_m[w_k] <= MagWidth'(w_tm >> (r_len - 7'(MagWidth)));
                    end else begin
                        r_m[w_k] <= MagWidth'(w_tm << (7'(MagWidth) - r_len));
                    end
                end else if (r_step < 3'd5) begin
                    // square and accumulate
                    r_s <= r_s + SumWidth'(w_prod);
                end else begin
                    // last square goes straight into the root remainder
                    r_rem <= 64'(r_s + SumWidth'(w_prod));
                    r_res <= '0;
                    r_bit <= 64'(1) << 62;
                end
            end
            ST_ROOT: begin
                if (r_bit != '0) begin
                    if (r_rem >= w_rb) begin
                        r_rem <= r_rem - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_out[r_step[1:0]] <= r_neg[r_step[1:0]]
                        ? OutWidth'(-w_q) : OutWidth'(w_q);
                    if (r_step == 3'd2) r_deg <= 1'b0;
                end
            end
            default: ;
        endcase
        // output register
        if (w_load_out) begin
            r_oval <= r_out;
            r_odeg <= r_deg;
        end
    end

    `TTU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == ST_IDLE && !r_ovalid,
        "sequencer not idle after reset")
    `TTU_ASSERT(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE |-> !i_vtx.ready,
        "vertex accepted while busy")
    `TTU_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(o_tan.valid) |-> $past(r_state) == ST_OUT,
        "result without finished sequence")
    `TTU_ASSERT(a_hold_result, i_clk, i_rst_n,
        o_tan.valid && !o_tan.ready |=> o_tan.valid && $stable(o_tan.data),
        "result changed while waiting")
endmodule
